// File: sv/cqrp_pkg.sv
// ----------------------------------------------------------------------------
// Circular queue with prefix reverse: shared package
// Field widths, status and action codes, the control word layout and the
// microprogram that the sequencer steps through.
// ----------------------------------------------------------------------------
package cqrp_pkg;

    // Fixed payload widths of the item and result fields.
    localparam int DATA_W   = 32;
    localparam int ACTION_W = 2;
    localparam int K_W      = 3;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 3;

    typedef logic [ACTION_W-1:0] t_action;
    typedef logic [STATUS_W-1:0] t_status;

    // Actions carried by an input item.
    localparam t_action ACT_ENQ  = 2'd0;
    localparam t_action ACT_DEQ  = 2'd1;
    localparam t_action ACT_PEEK = 2'd2;
    localparam t_action ACT_REV  = 2'd3;

    // Status codes of a result.
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;
    localparam t_status ST_BADK  = 2'd3;

    // Microprogram addresses. A check step falls through to the step that
    // follows it and jumps to its target when the condition holds.
    typedef logic [4:0] t_upc;
    localparam t_upc U_FETCH    = 5'd0;
    localparam t_upc U_DISP     = 5'd1;
    localparam t_upc U_ENQ_CHK  = 5'd2;
    localparam t_upc U_ENQ_WR   = 5'd3;
    localparam t_upc U_ENQ_FULL = 5'd4;
    localparam t_upc U_DEQ_CHK  = 5'd5;
    localparam t_upc U_DEQ_OUT  = 5'd6;
    localparam t_upc U_PEEK_CHK = 5'd7;
    localparam t_upc U_PEEK_OUT = 5'd8;
    localparam t_upc U_EMPTY    = 5'd9;
    localparam t_upc U_REV_CHK  = 5'd10;
    localparam t_upc U_REV_TEST = 5'd11;
    localparam t_upc U_REV_RDB  = 5'd12;
    localparam t_upc U_REV_WRA  = 5'd13;
    localparam t_upc U_REV_WRB  = 5'd14;
    localparam t_upc U_REV_BAD  = 5'd15;
    localparam t_upc U_REV_DONE = 5'd16;

    // Jump conditions.
    typedef logic [2:0] t_cond;
    localparam t_cond C_NEXT     = 3'd0;
    localparam t_cond C_ALWAYS   = 3'd1;
    localparam t_cond C_FULL     = 3'd2;
    localparam t_cond C_EMPTY    = 3'd3;
    localparam t_cond C_BADK     = 3'd4;
    localparam t_cond C_NOSWAP   = 3'd5;
    localparam t_cond C_DISPATCH = 3'd6;

    // Memory read address select.
    typedef logic [1:0] t_rd_sel;
    localparam t_rd_sel RD_NONE = 2'd0;
    localparam t_rd_sel RD_HEAD = 2'd1;
    localparam t_rd_sel RD_LO   = 2'd2;
    localparam t_rd_sel RD_HI   = 2'd3;

    // Memory write select; the write data follows from the address choice.
    typedef logic [1:0] t_wr_sel;
    localparam t_wr_sel WR_NONE = 2'd0;
    localparam t_wr_sel WR_TAIL = 2'd1;
    localparam t_wr_sel WR_LO   = 2'd2;
    localparam t_wr_sel WR_HI   = 2'd3;

    // Pointer and count updates.
    typedef logic [1:0] t_ptr_op;
    localparam t_ptr_op PO_NONE = 2'd0;
    localparam t_ptr_op PO_ENQ  = 2'd1;
    localparam t_ptr_op PO_DEQ  = 2'd2;
    localparam t_ptr_op PO_SWAP = 2'd3;

    // One control word of the microprogram.
    typedef struct packed {
        logic    take_in;   // accept an input item in this step
        logic    setup;     // load the reverse window registers
        t_rd_sel rd_sel;
        t_wr_sel wr_sel;
        logic    tmp_ld;    // keep the read word for the second half of a swap
        t_ptr_op ptr_op;
        logic    emit;      // load the result register
        logic    data_rd;   // result data comes from the memory read
        t_status status;
        t_cond   cond;
        t_upc    target;
    } t_ctrl;

    // Status from the datapath that the sequencer branches on.
    typedef struct packed {
        logic    in_valid;
        logic    out_busy;
        logic    full;
        logic    empty;
        logic    bad_k;
        logic    no_swap;
        t_action action;
    } t_flags;

    // Entry point of the routine for each action.
    function automatic t_upc dispatch_target(input t_action act);
        t_upc t;
        unique case (act)
            ACT_ENQ:  t = U_ENQ_CHK;
            ACT_DEQ:  t = U_DEQ_CHK;
            ACT_PEEK: t = U_PEEK_CHK;
            ACT_REV:  t = U_REV_CHK;
            default:  t = U_FETCH;
        endcase
        return t;
    endfunction

    // The microprogram store.
    function automatic t_ctrl ucode(input t_upc pc);
        t_ctrl c;
        c        = '0;
        c.cond   = C_ALWAYS;
        c.target = U_FETCH;
        unique case (pc)
            U_FETCH: begin
                c.take_in = 1'b1;
                c.cond    = C_NEXT;
            end
            U_DISP: begin
                c.setup = 1'b1;
                c.cond  = C_DISPATCH;
            end
            U_ENQ_CHK: begin
                c.cond   = C_FULL;
                c.target = U_ENQ_FULL;
            end
            U_ENQ_FULL: begin
                c.emit   = 1'b1;
                c.status = ST_FULL;
            end
            U_ENQ_WR: begin
                c.wr_sel = WR_TAIL;
                c.ptr_op = PO_ENQ;
                c.emit   = 1'b1;
                c.status = ST_OK;
            end
            U_DEQ_CHK: begin
                c.rd_sel = RD_HEAD;
                c.cond   = C_EMPTY;
                c.target = U_EMPTY;
            end
            U_DEQ_OUT: begin
                c.ptr_op  = PO_DEQ;
                c.emit    = 1'b1;
                c.data_rd = 1'b1;
                c.status  = ST_OK;
            end
            U_PEEK_CHK: begin
                c.rd_sel = RD_HEAD;
                c.cond   = C_EMPTY;
                c.target = U_EMPTY;
            end
            U_PEEK_OUT: begin
                c.emit    = 1'b1;
                c.data_rd = 1'b1;
                c.status  = ST_OK;
            end
            U_EMPTY: begin
                c.emit   = 1'b1;
                c.status = ST_EMPTY;
            end
            U_REV_CHK: begin
                c.cond   = C_BADK;
                c.target = U_REV_BAD;
            end
            U_REV_TEST: begin
                c.rd_sel = RD_LO;
                c.cond   = C_NOSWAP;
                c.target = U_REV_DONE;
            end
            U_REV_RDB: begin
                c.rd_sel = RD_HI;
                c.tmp_ld = 1'b1;
                c.cond   = C_NEXT;
            end
            U_REV_WRA: begin
                c.wr_sel = WR_LO;
                c.cond   = C_NEXT;
            end
            U_REV_WRB: begin
                c.wr_sel = WR_HI;
                c.ptr_op = PO_SWAP;
                c.target = U_REV_TEST;
            end
            U_REV_BAD: begin
                c.emit   = 1'b1;
                c.status = ST_BADK;
            end
            U_REV_DONE: begin
                c.emit   = 1'b1;
                c.status = ST_OK;
            end
            default: begin
                c.cond   = C_ALWAYS;
                c.target = U_FETCH;
            end
        endcase
        return c;
    endfunction

endpackage

// File: sv/cqrp_in_if.sv
// ----------------------------------------------------------------------------
// Circular queue with prefix reverse: input channel
// Valid/ready channel that carries one action item.
// ----------------------------------------------------------------------------
interface cqrp_in_if
    import cqrp_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [ACTION_W-1:0]      action;
    logic signed [DATA_W-1:0] value;
    logic [K_W-1:0]           count_k;

    modport source (output valid, output action, output value, output count_k,
                    input ready);
    modport sink   (input valid, input action, input value, input count_k,
                    output ready);
endinterface

// File: sv/cqrp_out_if.sv
// ----------------------------------------------------------------------------
// Circular queue with prefix reverse: result channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface cqrp_out_if
    import cqrp_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] data_out;
    logic [STATUS_W-1:0]      status;
    logic [OCC_W-1:0]         occupancy;
    logic                     is_empty;
    logic                     is_full;

    modport source (output valid, output data_out, output status, output occupancy,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input data_out, input status, input occupancy,
                    input is_empty, input is_full, output ready);
endinterface

// File: sv/cqrp_useq.sv
// ----------------------------------------------------------------------------
// Circular queue with prefix reverse: microsequencer
// Step counter, microprogram lookup and conditional jump logic.
// ----------------------------------------------------------------------------
module cqrp_useq
    import cqrp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_ctrl  o_ctrl,
    output logic   o_go
);

    t_upc  r_upc;
    t_upc  n_upc;
    t_ctrl cw;
    logic  jump;

    // Fetch the control word of the current step.
    assign cw     = ucode(r_upc);
    assign o_ctrl = cw;

    // A step stalls while it waits for an input transfer or for the result slot.
    assign o_go = !(cw.take_in && !i_flags.in_valid) && !(cw.emit && i_flags.out_busy);

    // Evaluate the jump condition.
    always_comb begin
        unique case (cw.cond)
            C_NEXT:   jump = 1'b0;
            C_ALWAYS: jump = 1'b1;
            C_FULL:   jump = i_flags.full;
            C_EMPTY:  jump = i_flags.empty;
            C_BADK:   jump = i_flags.bad_k;
            C_NOSWAP: jump = i_flags.no_swap;
            default:  jump = 1'b0;
        endcase
    end

    // Next step address.
    always_comb begin
        if (!o_go) begin
            n_upc = r_upc;
        end else if (cw.cond == C_DISPATCH) begin
            n_upc = dispatch_target(i_flags.action);
        end else if (jump) begin
            n_upc = cw.target;
        end else begin
            n_upc = r_upc + 5'd1;
        end
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_FETCH;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

// File: sv/cqrp_dpath.sv
// ----------------------------------------------------------------------------
// Circular queue with prefix reverse: datapath
// Entry memory, head/tail pointers, reverse window and result register.
// ----------------------------------------------------------------------------
module cqrp_dpath
    import cqrp_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl             i_ctrl,
    input  logic              i_go,
    output t_flags            o_flags,
    cqrp_in_if.sink           i_item,
    cqrp_out_if.source        o_result
);

    localparam int PW = $clog2(DEPTH);
    localparam int EW = (PW > K_W) ? PW : K_W;
    localparam int SW = EW + 1;
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    // Entry memory with registered read data.
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Queue state.
    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [PW-1:0] r_count, n_count;

    // Latched input item.
    t_action           r_act;
    logic [DATA_W-1:0] r_val;
    logic [K_W-1:0]    r_k;

    // Reverse window.
    logic [PW-1:0]     r_lo;
    logic [PW-1:0]     r_hi;
    logic [K_W-2:0]    r_swaps;
    logic [DATA_W-1:0] r_tmp;

    // Result register.
    logic              r_ovalid;
    logic [DATA_W-1:0] r_odata;
    t_status           r_ostat;
    logic [OCC_W-1:0]  r_occ;
    logic              r_oempty;
    logic              r_ofull;

    logic [PW-1:0]     rd_addr;
    logic [PW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              wr_en;
    logic              rd_en;
    logic [SW-1:0]     hi_sum;
    logic [SW-1:0]     hi_wrap;
    logic [EW-1:0]     k_ext;
    logic [EW-1:0]     cnt_ext;
    logic [EW-1:0]     occ_ext;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
        return (p == '0) ? PTR_LAST : p - PW'(1);
    endfunction

    // Status seen by the sequencer.
    assign k_ext   = EW'(r_k);
    assign cnt_ext = EW'(r_count);
    always_comb begin
        o_flags          = '0;
        o_flags.in_valid = i_item.valid;
        o_flags.out_busy = r_ovalid && !o_result.ready;
        o_flags.full     = (r_count == PTR_LAST);
        o_flags.empty    = (r_count == '0);
        o_flags.bad_k    = (r_k == '0) || (k_ext > cnt_ext);
        o_flags.no_swap  = (r_swaps == '0);
        o_flags.action   = r_act;
    end

    // Far end of the reverse window: head + k - 1, wrapped once.
    assign hi_sum  = SW'(r_head) + SW'(r_k) - SW'(1);
    assign hi_wrap = (hi_sum >= SW'(DEPTH)) ? hi_sum - SW'(DEPTH) : hi_sum;

    // Memory address and data selection.
    always_comb begin
        case (i_ctrl.rd_sel)
            RD_HEAD: rd_addr = r_head;
            RD_LO:   rd_addr = r_lo;
            RD_HI:   rd_addr = r_hi;
            default: rd_addr = r_head;
        endcase
        case (i_ctrl.wr_sel)
            WR_TAIL: begin
                wr_addr = r_tail;
                wr_data = r_val;
            end
            WR_LO: begin
                wr_addr = r_lo;
                wr_data = r_rd_data;
            end
            WR_HI: begin
                wr_addr = r_hi;
                wr_data = r_tmp;
            end
            default: begin
                wr_addr = r_tail;
                wr_data = r_val;
            end
        endcase
    end
    assign rd_en = i_go && (i_ctrl.rd_sel != RD_NONE);
    assign wr_en = i_go && (i_ctrl.wr_sel != WR_NONE);

    // Memory ports.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Pointer and count updates.
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_go) begin
            case (i_ctrl.ptr_op)
                PO_ENQ: begin
                    n_tail  = ptr_inc(r_tail);
                    n_count = r_count + PW'(1);
                end
                PO_DEQ: begin
                    n_head  = ptr_inc(r_head);
                    n_count = r_count - PW'(1);
                end
                default: begin
                    n_head = r_head;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Item latch, reverse window and swap holding register.
    always_ff @(posedge i_clk) begin
        if (i_go && i_ctrl.take_in) begin
            r_act <= i_item.action;
            r_val <= i_item.value;
            r_k   <= i_item.count_k;
        end
        if (i_go && i_ctrl.setup) begin
            r_lo    <= r_head;
            r_hi    <= hi_wrap[PW-1:0];
            r_swaps <= r_k[K_W-1:1];
        end else if (i_go && (i_ctrl.ptr_op == PO_SWAP)) begin
            r_lo    <= ptr_inc(r_lo);
            r_hi    <= ptr_dec(r_hi);
            r_swaps <= r_swaps - 1'b1;
        end
        if (i_go && i_ctrl.tmp_ld) begin
            r_tmp <= r_rd_data;
        end
    end

    // Result register; it reports the occupancy after the action.
    assign occ_ext = EW'(n_count);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_go && i_ctrl.emit) begin
            r_ovalid <= 1'b1;
        end else if (o_result.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go && i_ctrl.emit) begin
            r_odata  <= i_ctrl.data_rd ? r_rd_data : '0;
            r_ostat  <= i_ctrl.status;
            r_occ    <= occ_ext[OCC_W-1:0];
            r_oempty <= (n_count == '0);
            r_ofull  <= (n_count == PTR_LAST);
        end
    end

    // Channel outputs.
    assign i_item.ready       = i_ctrl.take_in;
    assign o_result.valid     = r_ovalid;
    assign o_result.data_out  = r_odata;
    assign o_result.status    = r_ostat;
    assign o_result.occupancy = r_occ;
    assign o_result.is_empty  = r_oempty;
    assign o_result.is_full   = r_ofull;

endmodule

// File: sv/circular_queue_reverse_prefix.sv
// Enqueue, dequeue, peek and rejected items run fetch (transfer), dispatch, check and emit.
// A valid reverse of k entries does floor(k/2) swaps: test, read, write lo, write hi.
// Items are handled one at a time; a new item is taken in the cycle after the result is loaded,
// and a result still waiting stalls the emit step.
// Each cycle the microprogram runs one step unless it stalls, with one memory read and write.
// Reset: head, tail, count and result valid clear and the sequencer returns to fetch.
// ----------------------------------------------------------------------------
// Circular queue with prefix reverse: top level
// Microcoded queue of signed words with enqueue, dequeue, peek and an
// in-place reverse of the first k entries.
// ----------------------------------------------------------------------------
module circular_queue_reverse_prefix
    import cqrp_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cqrp_in_if.sink     i_item,
    cqrp_out_if.source  o_result
);

    t_ctrl  ctrl;
    t_flags flags;
    logic   go;

    // Microprogram sequencer.
    cqrp_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl),
        .o_go    (go)
    );

    // Queue datapath.
    cqrp_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_go     (go),
        .o_flags  (flags),
        .i_item   (i_item),
        .o_result (o_result)
    );

endmodule
